// File: design/tpud_pkg.sv
package tpud_pkg;

	// default widths
	localparam int COORD_BITS_DEF = 12;
	localparam int TICK_BITS_DEF  = 11;

	// configuration port
	localparam int CFG_IDX_W = 3;

	typedef logic [2:0] cmd_t;
	typedef logic [2:0] quad_t;
	typedef logic [1:0] prog_t;
	typedef logic [1:0] mode_t;

	// event kinds
	localparam cmd_t CMD_TICK    = 3'd0;
	localparam cmd_t CMD_SLOT    = 3'd1;
	localparam cmd_t CMD_RELEASE = 3'd2;
	localparam cmd_t CMD_POS_X   = 3'd3;
	localparam cmd_t CMD_POS_Y   = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_1   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_3   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MID_H   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MID_V   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIM = 3'd7;

	// quadrant codes
	localparam quad_t QUAD_UL = 3'd1;
	localparam quad_t QUAD_UR = 3'd2;
	localparam quad_t QUAD_LL = 3'd3;
	localparam quad_t QUAD_LR = 3'd4;

	// reset values of the registers
	localparam mode_t ENABLE_RST    = 2'd0;
	localparam quad_t PAT_0_RST     = QUAD_UL;
	localparam quad_t PAT_1_RST     = QUAD_UR;
	localparam quad_t PAT_2_RST     = QUAD_LL;
	localparam quad_t PAT_3_RST     = QUAD_LR;
	localparam int    MID_H_RST     = 240;
	localparam int    MID_V_RST     = 427;
	localparam int    GAP_LIMIT_RST = 600;

	// last progress step before the final tap
	localparam prog_t PROG_LAST = 2'd3;

endpackage

// File: design/tpud_if.sv
// touch event channel
interface tpud_evt_if #(
	parameter int COORD_BITS = tpud_pkg::COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	tpud_pkg::cmd_t        cmd;
	logic [COORD_BITS-1:0] value;
	logic                  screen_off;

	modport source (output valid, cmd, value, screen_off, input ready);
	modport sink   (input valid, cmd, value, screen_off, output ready);
endinterface

// result channel
interface tpud_res_if;
	logic            valid;
	logic            ready;
	logic            unlock;
	tpud_pkg::prog_t taps_matched;
	logic            release_armed;

	modport source (output valid, unlock, taps_matched, release_armed, input ready);
	modport sink   (input valid, unlock, taps_matched, release_armed, output ready);
endinterface

// configuration write channel
interface tpud_cfg_if #(
	parameter int DATA_W = tpud_pkg::COORD_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [tpud_pkg::CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]              data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: design/tap_pattern_unlock_detector_core.sv
// Knock-pattern wake detector.
// Channels: evt takes one decoded touch event per transaction (tick, slot
// change, release, X or Y position, with the coordinate and the screen-off
// flag); res gives exactly one result per event: the unlock pulse, the taps
// matched so far and the armed flag; cfg writes the eight registers by index
// (enable, the four pattern taps, the two midlines, the gap limit) and is
// always ready. The user must write registers only while no event is in
// flight; the block itself does not enforce this. Path: an accepted event
// is held in the event register, judged against the stored state and loaded
// into the result register once the result slot is free. Throughput: one
// event per cycle unless res is held off; the quadrant compare, pattern
// compare and tick counter all settle between the event and result registers.
// Reset: arst_n clears coordinates, armed flag, progress and tick count and
// loads the register defaults; no result is pending afterwards.
// Stall: while res is held off the result register keeps its transaction and
// the event register holds one more event; evt drops ready only when both are
// full, and picks up again in the cycle res is taken.
module tap_pattern_unlock_detector_core #(
	parameter int COORD_BITS = tpud_pkg::COORD_BITS_DEF,
	parameter int TICK_BITS  = tpud_pkg::TICK_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	tpud_evt_if.sink       evt,
	tpud_res_if.source     res,
	tpud_cfg_if.sink       cfg
);
	import tpud_pkg::*;

	localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

	// configuration registers
	mode_t                 enable_q;
	quad_t                 pattern_q [4];
	logic [COORD_BITS-1:0] mid_h_q;
	logic [COORD_BITS-1:0] mid_v_q;
	logic [TICK_BITS-1:0]  gap_limit_q;

	// detector state
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;
	logic                  armed_q;
	prog_t                 progress_q;
	logic [TICK_BITS-1:0]  elapsed_q;

	// event register
	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [COORD_BITS-1:0] value_s1;
	logic                  off_s1;

	// result register
	logic                  res_valid_q;
	logic                  unlock_q;
	prog_t                 taps_q;
	logic                  armed_out_q;

	// next-state values
	logic [COORD_BITS-1:0] last_x_n;
	logic [COORD_BITS-1:0] last_y_n;
	logic                  armed_n;
	prog_t                 progress_n;
	logic [TICK_BITS-1:0]  elapsed_n;
	logic                  fire_n;
	prog_t                 prog_eff;
	quad_t                 quad;
	logic                  advance;

	// handshake: the result slot frees when empty or taken
	assign advance   = !res_valid_q || res.ready;
	assign evt.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign res.valid         = res_valid_q;
	assign res.unlock        = unlock_q;
	assign res.taps_matched  = taps_q;
	assign res.release_armed = armed_out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= ENABLE_RST;
			pattern_q[0] <= PAT_0_RST;
			pattern_q[1] <= PAT_1_RST;
			pattern_q[2] <= PAT_2_RST;
			pattern_q[3] <= PAT_3_RST;
			mid_h_q      <= COORD_BITS'(MID_H_RST);
			mid_v_q      <= COORD_BITS'(MID_V_RST);
			gap_limit_q  <= TICK_BITS'(GAP_LIMIT_RST);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ENABLE:  enable_q     <= cfg.data[1:0];
				REG_PAT_0:   pattern_q[0] <= cfg.data[2:0];
				REG_PAT_1:   pattern_q[1] <= cfg.data[2:0];
				REG_PAT_2:   pattern_q[2] <= cfg.data[2:0];
				REG_PAT_3:   pattern_q[3] <= cfg.data[2:0];
				REG_MID_H:   mid_h_q      <= cfg.data[COORD_BITS-1:0];
				REG_MID_V:   mid_v_q      <= cfg.data[COORD_BITS-1:0];
				REG_GAP_LIM: gap_limit_q  <= cfg.data[TICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			cmd_s1   <= evt.cmd;
			value_s1 <= evt.value;
			off_s1   <= evt.screen_off;
		end
	end

	// coordinate update, tap judgement and tick count
	always_comb begin
		last_x_n   = last_x_q;
		last_y_n   = last_y_q;
		armed_n    = armed_q;
		progress_n = progress_q;
		elapsed_n  = elapsed_q;
		fire_n     = 1'b0;
		prog_eff   = progress_q;
		quad       = QUAD_UL;

		case (cmd_s1)
			CMD_TICK: begin
				if (elapsed_q != TICK_MAX)
					elapsed_n = elapsed_q + 1'b1;
			end
			CMD_SLOT: begin
				if (off_s1)
					progress_n = '0;
			end
			CMD_RELEASE: begin
				if (off_s1)
					armed_n = 1'b1;
			end
			CMD_POS_X, CMD_POS_Y: begin
				if (off_s1) begin
					if (cmd_s1 == CMD_POS_X)
						last_x_n = value_s1;
					else
						last_y_n = value_s1;

					// quadrant of the latest point
					quad = (last_y_n < mid_v_q) ? QUAD_UL : QUAD_LL;
					if (last_x_n >= mid_h_q)
						quad = quad + 1'b1;

					if (enable_q != '0 && armed_q) begin
						armed_n = 1'b0;
						// too long since the last accepted tap
						if (progress_q != '0 && elapsed_q > gap_limit_q)
							prog_eff = '0;
						if (prog_eff != PROG_LAST) begin
							if (quad == pattern_q[prog_eff]) begin
								elapsed_n  = '0;
								progress_n = prog_eff + 1'b1;
							end else begin
								progress_n = '0;
							end
						end else begin
							fire_n     = (quad == pattern_q[PROG_LAST]);
							progress_n = '0;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// state registers follow each event as it leaves the event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q   <= '0;
			last_y_q   <= '0;
			armed_q    <= 1'b0;
			progress_q <= '0;
			elapsed_q  <= '0;
		end else if (valid_s1 && advance) begin
			last_x_q   <= last_x_n;
			last_y_q   <= last_y_n;
			armed_q    <= armed_n;
			progress_q <= progress_n;
			elapsed_q  <= elapsed_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			unlock_q    <= fire_n;
			taps_q      <= progress_n;
			armed_out_q <= armed_n;
		end
	end

endmodule
